### rtl/p2h_pkg.sv
// Shared types, constants and helpers for the pixel to half-float converter.
// No dependencies.
package p2h_pkg;

    localparam logic [1:0]  KIND_U8   = 2'd0;
    localparam logic [1:0]  KIND_U16  = 2'd1;
    localparam logic [1:0]  KIND_F32  = 2'd2;
    localparam logic [0:0]  REG_SOURCE_KIND = 1'b0;
    localparam logic [0:0]  REG_FORCE_ALPHA = 1'b1;
    localparam logic [15:0] HALF_ONE  = 16'h3C00;
    localparam logic [14:0] HALF_INF  = 15'h7C00;
    localparam logic [31:0] SGL_ONE   = 32'h3F80_0000;

    typedef struct packed {
        logic [31:0] chan_r;
        logic [31:0] chan_g;
        logic [31:0] chan_b;
        logic [31:0] chan_a;
        logic        last_pixel;
    } t_pix_in;

    typedef struct packed {
        logic [15:0] half_r;
        logic [15:0] half_g;
        logic [15:0] half_b;
        logic [15:0] half_a;
        logic        last_pixel_out;
    } t_pix_out;

    // Leading zero count of a non-zero 16-bit word.
    function automatic logic [3:0] lzc16(input logic [15:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                n = 4'(15 - i);
            end
        end
        return n;
    endfunction

endpackage

### rtl/p2h_norm.sv
// Two register stages that turn one raw channel word into single-precision bits.
// Depends on p2h_pkg.
module p2h_norm import p2h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_word,
    output logic [31:0] o_bits
);
    // A value v over 2^k-1 has the k-bit pattern of v repeating after the point.
    logic [15:0] v;
    logic [63:0] rep;
    logic [3:0]  lz;
    logic        all_ones;
    logic [63:0] r_win;
    logic [7:0]  r_exp;
    logic        r_zero, r_one, r_float;
    logic [31:0] r_word;
    logic [24:0] rmant;
    logic [7:0]  exp_b;
    logic [22:0] frac_b;
    logic [31:0] n_bits;
    logic [31:0] r_bits;

    always_comb begin
        if (i_kind == KIND_U8) begin
            v        = {8'h00, i_word[7:0]};
            rep      = {8{i_word[7:0]}};
            lz       = lzc16({i_word[7:0], 8'hFF});
            all_ones = (i_word[7:0] == 8'hFF);
        end else begin
            v        = i_word[15:0];
            rep      = {4{i_word[15:0]}};
            lz       = lzc16(i_word[15:0]);
            all_ones = (i_word[15:0] == 16'hFFFF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win   <= rep << lz;
            r_exp   <= 8'd126 - {4'd0, lz};
            r_zero  <= (v == 16'd0);
            r_one   <= all_ones;
            r_float <= i_kind[1];
            r_word  <= i_word;
        end
    end

    // The tail is never zero, so a set guard bit always rounds up.
    always_comb begin
        rmant  = {1'b0, r_win[63:40]} + {24'd0, r_win[39]};
        exp_b  = rmant[24] ? r_exp + 8'd1 : r_exp;
        frac_b = rmant[24] ? 23'd0 : rmant[22:0];
        priority if (r_float) begin
            n_bits = r_word;
        end else if (r_zero) begin
            n_bits = 32'd0;
        end else if (r_one) begin
            n_bits = SGL_ONE;
        end else begin
            n_bits = {1'b0, exp_b, frac_b};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    assign o_bits = r_bits;
endmodule

### rtl/p2h_narrow.sv
// Register stage that narrows single-precision bits to a half-precision pattern.
// Depends on p2h_pkg.
module p2h_narrow import p2h_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_bits,
    output logic [15:0] o_half
);
    logic        sign;
    logic [7:0]  e8;
    logic [23:0] m24;
    logic [4:0]  sh;
    logic [23:0] sub_h;
    logic        sub_rb;
    logic [14:0] mag;
    logic [15:0] r_half;

    always_comb begin
        sign   = i_bits[31];
        e8     = i_bits[30:23];
        m24    = {1'b1, i_bits[22:0]};
        sh     = 5'(8'd126 - e8);
        sub_h  = m24 >> sh;
        sub_rb = m24[sh - 5'd1];
        priority if (e8 < 8'd102) begin
            mag = 15'd0;
        end else if (e8 <= 8'd112) begin
            mag = 15'(sub_h) + {14'd0, sub_rb};
        end else if (e8 >= 8'd143) begin
            mag = HALF_INF;
        end else begin
            mag = {5'(e8 - 8'd112), i_bits[22:13]} + {14'd0, i_bits[12]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_half <= {sign, mag};
    end

    assign o_half = r_half;
endmodule

### rtl/pixel_to_half_float_converter.sv
// Throughput: one pixel per clock; o_busy is always low, three register stages
// (normalise, round to single, narrow to half) per channel with valid bits.
// Reset clears the valid bits and sets source_kind to 1 and force_opaque_alpha to 0.
// The receiver cannot stall; o_valid marks each result for one cycle.
module pixel_to_half_float_converter import p2h_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_pix_in    i_pixel,
    output logic       o_busy,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    output logic       o_valid,
    output t_pix_out   o_pixel
);
    logic [1:0]  r_kind;
    logic        r_force;
    logic        accept;
    logic [2:0]  r_valid;
    logic [2:0]  r_last;
    logic [2:0]  r_frc;
    logic [31:0] bits_r, bits_g, bits_b, bits_a;
    logic [15:0] half_r, half_g, half_b, half_a;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_U16;
            r_force <= 1'b0;
            r_valid <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SOURCE_KIND: r_kind  <= i_cfg_data;
                    REG_FORCE_ALPHA: r_force <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_valid <= {r_valid[1:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[1:0], i_pixel.last_pixel};
        r_frc  <= {r_frc[1:0], r_force};
    end

    p2h_norm u_norm_r (.i_clk, .i_load(accept), .i_kind(r_kind), .i_word(i_pixel.chan_r), .o_bits(bits_r));
    p2h_norm u_norm_g (.i_clk, .i_load(accept), .i_kind(r_kind), .i_word(i_pixel.chan_g), .o_bits(bits_g));
    p2h_norm u_norm_b (.i_clk, .i_load(accept), .i_kind(r_kind), .i_word(i_pixel.chan_b), .o_bits(bits_b));
    p2h_norm u_norm_a (.i_clk, .i_load(accept), .i_kind(r_kind), .i_word(i_pixel.chan_a), .o_bits(bits_a));

    p2h_narrow u_nar_r (.i_clk, .i_bits(bits_r), .o_half(half_r));
    p2h_narrow u_nar_g (.i_clk, .i_bits(bits_g), .o_half(half_g));
    p2h_narrow u_nar_b (.i_clk, .i_bits(bits_b), .o_half(half_b));
    p2h_narrow u_nar_a (.i_clk, .i_bits(bits_a), .o_half(half_a));

    assign o_valid                = r_valid[2];
    assign o_pixel.half_r         = half_r;
    assign o_pixel.half_g         = half_g;
    assign o_pixel.half_b         = half_b;
    assign o_pixel.half_a         = r_frc[2] ? HALF_ONE : half_a;
    assign o_pixel.last_pixel_out = r_last[2];

    a_valid_latency: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3))
        |-> (o_valid == $past(i_start, 3)))
        else $error("result strobe does not follow the transaction by three cycles");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel.last_pixel_out == $past(i_pixel.last_pixel, 3)))
        else $error("last-pixel mark out of step with its transaction");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("busy raised while results stream");
endmodule
